// File: rtl/core/sfdp_pkg.sv
// Shared constants and types for the scaled float dot product block.
// Used by the channel interfaces, the top level and its checker.
`default_nettype none

package sfdp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WIN_W  = 80;

  typedef logic [DATA_W-1:0] fp_t;
  typedef logic signed [11:0] exp_t;

  localparam fp_t FP_CANON_NAN = 32'h7FC0_0000;
  localparam fp_t FP_ONE       = 32'h3F80_0000;
  localparam fp_t FP_POS_ZERO  = 32'h0000_0000;
  localparam logic [7:0] EXP_MAX = 8'hFF;

endpackage

`default_nettype wire

// File: rtl/core/sfdp_ifs.sv
// Valid/ready channel interfaces for the scaled float dot product block.
// Depends on sfdp_pkg for the data width.
`default_nettype none

interface sfdp_in_if;
  logic              valid;
  logic              ready;
  sfdp_pkg::fp_t     query_element;
  sfdp_pkg::fp_t     stored_element;
  logic              last_element;

  modport source (output valid, output query_element, output stored_element,
                  output last_element, input ready);
  modport sink   (input valid, input query_element, input stored_element,
                  input last_element, output ready);
endinterface

interface sfdp_out_if;
  logic              valid;
  logic              ready;
  sfdp_pkg::fp_t     score;
  sfdp_pkg::fp_t     raw_sum;

  modport source (output valid, output score, output raw_sum, input ready);
  modport sink   (input valid, input score, input raw_sum, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scaled_float_dot_product.sv
// Top level of the scaled float dot product block: sequencer and shared datapath.
// Depends on sfdp_pkg and the channel interfaces in sfdp_ifs.sv.
`default_nettype none

// The block accumulates query*stored element pairs into a single-precision
// running sum with a correctly rounded fused multiply-add (round to nearest
// even, subnormals kept, NaNs canonicalized to 0x7FC00000). On a pair that
// carries last_element it delivers one result transfer holding the raw sum
// and the score (1/(1-sum) for a negative sum, sum+1 otherwise) and clears
// the accumulator. One shared multiply-add unit is run by a small sequencer:
// an operand pass, an align-and-add pass, a normalize loop that moves the
// leading one by 16, 4 or 1 bits a cycle, and a rounding pass. How long a
// pair holds the block is set by special operands, which skip the adder,
// and by the length of the normalize loop, which grows after deep
// cancellation; in_ch.ready is low while a pair is in work. A final pair
// runs the unit once more for the score before the output register is
// loaded, and a negative sum adds a restoring reciprocal loop plus one
// more normalize and round. The result sits in an output register, so the
// next pair is accepted while a finished result still waits for its transfer.
module scaled_float_dot_product (
  input  wire         clk,
  input  wire         rst_n,
  sfdp_in_if.sink     in_ch,
  sfdp_out_if.source  out_ch
);

  localparam int unsigned W = sfdp_pkg::WIN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADD, S_NORM, S_RND, S_FIN, S_DIV, S_OUT
  } state_t;

  typedef enum logic [1:0] {OP_ACC, OP_ADD1, OP_SUB1, OP_DIV} op_t;

  typedef struct packed {
    logic              zero;
    logic              inf;
    logic              nan;
    logic              sgn;
    logic [23:0]       man;
    sfdp_pkg::exp_t    lsb;
  } unp_t;

  // Splits a single into sign, a mantissa with its leading one at bit 23
  // and the exponent of the mantissa's least significant bit.
  function automatic unp_t unpack(input sfdp_pkg::fp_t f);
    unp_t        u;
    logic [4:0]  lz;
    logic [23:0] fr;
    u.sgn  = f[31];
    u.zero = (f[30:0] == 31'd0);
    u.inf  = (f[30:23] == sfdp_pkg::EXP_MAX) && (f[22:0] == 23'd0);
    u.nan  = (f[30:23] == sfdp_pkg::EXP_MAX) && (f[22:0] != 23'd0);
    fr = {1'b0, f[22:0]};
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (!fr[23-i] && (lz == 5'(i))) begin
        lz = 5'(i + 1);
      end
    end
    if (f[30:23] == 8'd0) begin
      u.man = fr << lz;
      u.lsb = -12'sd149 - $signed({7'd0, lz});
    end else begin
      u.man = {1'b1, f[22:0]};
      u.lsb = $signed({4'd0, f[30:23]}) - 12'sd150;
    end
    return u;
  endfunction

  state_t          state_r;
  op_t             op_r;
  logic            last_r;
  sfdp_pkg::fp_t   a_r, b_r, c_r;
  sfdp_pkg::fp_t   acc_r, sum_r, score_r, res_r;
  logic            out_valid_r;
  sfdp_pkg::fp_t   out_score_r, out_sum_r;
  logic [47:0]     xm_r, ym_r;
  logic            xs_r, ys_r;
  logic [6:0]      d_r;
  sfdp_pkg::exp_t  ex_r, e_r;
  logic [W-1:0]    m_r;
  logic            sg_r;
  logic [23:0]     md_r;
  logic [24:0]     rem_r;
  logic [27:0]     q_r;
  logic [4:0]      cnt_r;

  // Operand pass.
  unp_t            ua, ub, uc;
  logic            ps, pinf, pzero, is_nan, is_spec;
  sfdp_pkg::fp_t   spec_val;
  logic [47:0]     mp;
  sfdp_pkg::exp_t  ep, ec, ediff, eabs;
  logic [6:0]      dcl;

  always_comb begin
    ua = unpack(a_r);
    ub = unpack(b_r);
    uc = unpack(c_r);
    ps    = ua.sgn ^ ub.sgn;
    pinf  = ua.inf | ub.inf;
    pzero = ua.zero | ub.zero;
    is_nan = ua.nan | ub.nan | uc.nan | (pinf & pzero) |
             (pinf & uc.inf & (ps != uc.sgn));
    is_spec = is_nan | pinf | uc.inf | pzero;
    if (is_nan) begin
      spec_val = sfdp_pkg::FP_CANON_NAN;
    end else if (pinf) begin
      spec_val = {ps, sfdp_pkg::EXP_MAX, 23'd0};
    end else if (uc.inf) begin
      spec_val = {uc.sgn, sfdp_pkg::EXP_MAX, 23'd0};
    end else if (uc.zero) begin
      spec_val = {ps & uc.sgn, 31'd0};
    end else begin
      spec_val = c_r;
    end
    mp    = ua.man * ub.man;
    ep    = ua.lsb + ub.lsb;
    ec    = uc.lsb - 12'sd24;
    ediff = ep - ec;
    eabs  = ediff[11] ? -ediff : ediff;
    dcl   = (eabs > 12'sd81) ? 7'd81 : eabs[6:0];
  end

  // Align-and-add pass. The smaller operand's bits that fall below bit 1
  // collapse into a sticky bit at bit 0, which keeps rounding exact.
  logic [W-1:0] xw, yw, ysh, ylost, ya, addsum, mag;
  logic [W:0]   diff;
  logic         add_sgn;

  always_comb begin
    xw     = {1'b0, xm_r, 31'd0};
    yw     = {1'b0, ym_r, 31'd0};
    ysh    = yw >> d_r;
    ylost  = yw & ~({W{1'b1}} << d_r);
    ya     = {ysh[W-1:1], (|ylost) | ysh[0]};
    addsum = xw + ya;
    diff   = {1'b0, xw} - {1'b0, ya};
    if (xs_r == ys_r) begin
      mag     = addsum;
      add_sgn = xs_r;
    end else if (diff[W]) begin
      mag     = ya - xw;
      add_sgn = ~xs_r;
    end else begin
      mag     = diff[W-1:0];
      add_sgn = xs_r;
    end
  end

  // Rounding pass on a window normalized with its leading one at the top.
  sfdp_pkg::exp_t  lraw, lq, lf, rs_w, be;
  logic [6:0]      rs, rs1;
  logic [W-1:0]    kept_w, guard_w;
  logic            guard, sticky, inc;
  logic [24:0]     qr;
  logic [23:0]     qm;
  sfdp_pkg::fp_t   rnd_val;

  always_comb begin
    lraw    = e_r + 12'sd56;
    lq      = (lraw < -12'sd149) ? -12'sd149 : lraw;
    rs_w    = lq - e_r;
    rs      = (rs_w > 12'sd81) ? 7'd81 : rs_w[6:0];
    rs1     = rs - 7'd1;
    kept_w  = m_r >> rs;
    guard_w = m_r >> rs1;
    guard   = guard_w[0];
    sticky  = |(m_r & ~({W{1'b1}} << rs1));
    inc     = guard & (sticky | kept_w[0]);
    qr      = {1'b0, kept_w[23:0]} + {24'd0, inc};
    lf      = qr[24] ? lq + 12'sd1 : lq;
    qm      = qr[24] ? qr[24:1] : qr[23:0];
    be      = lf + 12'sd150;
    if (qm[23]) begin
      if (be >= 12'sd255) begin
        rnd_val = {sg_r, sfdp_pkg::EXP_MAX, 23'd0};
      end else begin
        rnd_val = {sg_r, be[7:0], qm[22:0]};
      end
    end else begin
      rnd_val = {sg_r, 8'd0, qm[22:0]};
    end
  end

  // Restoring reciprocal step.
  logic [24:0] rem_nxt;
  logic [27:0] q_nxt;
  logic        res_neg;

  always_comb begin
    if (rem_r >= {1'b0, md_r}) begin
      rem_nxt = (rem_r - {1'b0, md_r}) << 1;
      q_nxt   = {q_r[26:0], 1'b1};
    end else begin
      rem_nxt = rem_r << 1;
      q_nxt   = {q_r[26:0], 1'b0};
    end
    res_neg = res_r[31] && (res_r[30:0] != 31'd0);
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.score   = out_score_r;
  assign out_ch.raw_sum = out_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_ACC;
      out_valid_r <= 1'b0;
      acc_r       <= sfdp_pkg::FP_POS_ZERO;
    end else begin
      // In S_OUT the output register is reloaded below instead.
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            a_r     <= in_ch.query_element;
            b_r     <= in_ch.stored_element;
            c_r     <= acc_r;
            last_r  <= in_ch.last_element;
            op_r    <= OP_ACC;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (is_spec) begin
            res_r   <= spec_val;
            state_r <= S_FIN;
          end else begin
            if (uc.zero || !ediff[11]) begin
              xm_r <= mp;
              xs_r <= ps;
              ex_r <= ep;
              ym_r <= uc.zero ? 48'd0 : {uc.man, 24'd0};
              ys_r <= uc.zero ? ps : uc.sgn;
            end else begin
              xm_r <= {uc.man, 24'd0};
              xs_r <= uc.sgn;
              ex_r <= ec;
              ym_r <= mp;
              ys_r <= ps;
            end
            d_r     <= dcl;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (mag == '0) begin
            // Exact cancellation gives positive zero.
            res_r   <= sfdp_pkg::FP_POS_ZERO;
            state_r <= S_FIN;
          end else begin
            m_r     <= mag;
            e_r     <= ex_r - 12'sd31;
            sg_r    <= add_sgn;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_r[W-1:W-16] == 16'd0) begin
            m_r <= m_r << 16;
            e_r <= e_r - 12'sd16;
          end else if (m_r[W-1:W-4] == 4'd0) begin
            m_r <= m_r << 4;
            e_r <= e_r - 12'sd4;
          end else if (!m_r[W-1]) begin
            m_r <= m_r << 1;
            e_r <= e_r - 12'sd1;
          end else begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          res_r   <= rnd_val;
          state_r <= S_FIN;
        end
        S_FIN: begin
          unique case (op_r)
            OP_ACC: begin
              acc_r <= res_r;
              if (last_r) begin
                sum_r   <= res_r;
                a_r     <= res_neg ? {1'b0, res_r[30:0]} : res_r;
                b_r     <= sfdp_pkg::FP_ONE;
                c_r     <= sfdp_pkg::FP_ONE;
                op_r    <= res_neg ? OP_SUB1 : OP_ADD1;
                state_r <= S_MUL;
              end else begin
                state_r <= S_IDLE;
              end
            end
            OP_SUB1: begin
              if (res_r[30:23] == sfdp_pkg::EXP_MAX) begin
                // The sum was minus infinity.
                score_r <= sfdp_pkg::FP_POS_ZERO;
                state_r <= S_OUT;
              end else begin
                md_r    <= {1'b1, res_r[22:0]};
                rem_r   <= 25'h080_0000;
                q_r     <= 28'd0;
                cnt_r   <= 5'd0;
                e_r     <= 12'sd99 - $signed({4'd0, res_r[30:23]});
                sg_r    <= 1'b0;
                op_r    <= OP_DIV;
                state_r <= S_DIV;
              end
            end
            OP_ADD1, OP_DIV: begin
              score_r <= res_r;
              state_r <= S_OUT;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd27) begin
            m_r     <= {{(W-29){1'b0}}, q_nxt, |rem_nxt};
            state_r <= S_NORM;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_score_r <= score_r;
            out_sum_r   <= sum_r;
            out_valid_r <= 1'b1;
            acc_r       <= sfdp_pkg::FP_POS_ZERO;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sfdp_checker.sv
// Port-level checks for the scaled float dot product block, and the bind
// that attaches them to the top level. Depends on sfdp_pkg.
`default_nettype none

module sfdp_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire sfdp_pkg::fp_t out_score,
  input wire sfdp_pkg::fp_t out_raw_sum
);

  // A held result keeps its value until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(out_raw_sum))
    else $error("result changed or dropped before its transfer");

  // Each accepted pair keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // A new result is loaded only by the sequencer, while input is held off.
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind scaled_float_dot_product sfdp_checker u_sfdp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_score   (out_ch.score),
  .out_raw_sum (out_ch.raw_sum)
);

`default_nettype wire

// File: dv/tb.sv
// Testbench for scaled_float_dot_product: random and directed vector pairs,
// checked against a bit-exact single-precision predictor in a scoreboard.
// Depends on sfdp_pkg and the channel interfaces in sfdp_ifs.sv.
`timescale 1ns / 100ps

// Holds the running sum and the queue of expected results. A pair is noted
// when its transfer is seen; a result is checked against the oldest entry.
class sfdp_scoreboard;
  sfdp_pkg::fp_t acc_sum;
  sfdp_pkg::fp_t want_score[$];
  sfdp_pkg::fp_t want_sum[$];
  int  errors;

  function new();
    acc_sum = sfdp_pkg::FP_POS_ZERO;
    errors  = 0;
  endfunction

  // Exact widening of a single bit pattern into a double.
  static function real widen(sfdp_pkg::fp_t f);
    real r;
    if (f[30:23] == sfdp_pkg::EXP_MAX)
      return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'b0});
    if (f[30:0] == 31'b0)
      return $bitstoreal({f[31], 63'b0});
    if (f[30:23] == 8'h00) begin
      r = real'(f[22:0]) * (2.0 ** -149);
      return f[31] ? -r : r;
    end
    return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'b0});
  endfunction

  // Round a double to single, nearest even, keeping subnormals. NaN comes
  // out as the canonical quiet NaN.
  static function sfdp_pkg::fp_t narrow(real r);
    logic [63:0] u;
    logic [63:0] m;
    logic [63:0] q;
    int          e;
    int          sh;
    bit          guard;
    bit          sticky;
    u = $realtobits(r);
    if (u[62:52] == 11'h7FF)
      return (u[51:0] != 52'b0) ? sfdp_pkg::FP_CANON_NAN
                                : {u[63], sfdp_pkg::EXP_MAX, 23'b0};
    if (u[62:52] == 11'h000)
      return {u[63], 31'b0};
    e  = int'(u[62:52]) - 1023;
    m  = {11'b0, 1'b1, u[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60)
      return {u[63], 31'b0};
    q      = m >> sh;
    guard  = m[sh-1];
    sticky = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    if (guard && (sticky || q[0]))
      q = q + 64'd1;
    if (e >= -126) begin
      if (q[24]) begin
        q = q >> 1;
        e = e + 1;
      end
      if (e > 127)
        return {u[63], sfdp_pkg::EXP_MAX, 23'b0};
      return {u[63], 8'(e + 127), q[22:0]};
    end
    // Subnormal range; a carry into bit 23 lands on the smallest normal.
    return {u[63], q[30:0]};
  endfunction

  // a*b+c with a single rounding. The double sum is nudged by one ulp when
  // it sits exactly on a single-precision tie but the true value does not.
  static function sfdp_pkg::fp_t fused(sfdp_pkg::fp_t a, sfdp_pkg::fp_t b,
                                       sfdp_pkg::fp_t c);
    real         prod;
    real         addend;
    real         s;
    real         bv;
    real         err;
    logic [63:0] u;
    int          ed;
    int          quant;
    int          k;
    bit          tie;
    prod   = widen(a) * widen(b);
    addend = widen(c);
    s      = prod + addend;
    u      = $realtobits(s);
    if (u[62:52] == 11'h7FF || u[62:52] == 11'h000)
      return narrow(s);
    bv  = s - prod;
    err = (prod - (s - bv)) + (addend - bv);
    if (err == 0.0)
      return narrow(s);
    ed    = int'(u[62:52]) - 1023;
    quant = ed - 23;
    if (quant < -149)
      quant = -149;
    k = (quant - 1) - ed + 52;
    if (k < 0)
      tie = 1'b0;
    else if (k <= 51)
      tie = (u & ((64'd1 << (k + 1)) - 64'd1)) == (64'd1 << k);
    else if (k == 52)
      tie = u[51:0] == 52'b0;
    else
      tie = 1'b0;
    if (tie) begin
      if (u[63] == (err < 0.0))
        u = u + 64'd1;
      else
        u = u - 64'd1;
    end
    return narrow($bitstoreal(u));
  endfunction

  function void note_pair(sfdp_pkg::fp_t q, sfdp_pkg::fp_t s, bit last);
    sfdp_pkg::fp_t denom;
    sfdp_pkg::fp_t score;
    acc_sum = fused(q, s, acc_sum);
    if (!last)
      return;
    // Only a true negative sum takes the reciprocal path; -0 and NaN do not.
    if (acc_sum[31] && acc_sum[30:0] != 31'b0 &&
        !(acc_sum[30:23] == sfdp_pkg::EXP_MAX && acc_sum[22:0] != 23'b0)) begin
      denom = narrow(1.0 - widen(acc_sum));
      score = narrow(1.0 / widen(denom));
    end else begin
      score = narrow(widen(acc_sum) + 1.0);
    end
    want_score.push_back(score);
    want_sum.push_back(acc_sum);
    acc_sum = sfdp_pkg::FP_POS_ZERO;
  endfunction

  function void check_result(sfdp_pkg::fp_t score, sfdp_pkg::fp_t raw_sum);
    sfdp_pkg::fp_t exp_score;
    sfdp_pkg::fp_t exp_sum;
    if (want_score.size() == 0) begin
      $error("unexpected result: score %h raw_sum %h", score, raw_sum);
      errors++;
      return;
    end
    exp_score = want_score.pop_front();
    exp_sum   = want_sum.pop_front();
    if (score !== exp_score) begin
      $error("score: expected %h, got %h", exp_score, score);
      errors++;
    end
    if (raw_sum !== exp_sum) begin
      $error("raw_sum: expected %h, got %h", exp_sum, raw_sum);
      errors++;
    end
  endfunction

  function int pending();
    return want_score.size();
  endfunction
endclass

module tb;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PAIR_TARGET = 1350;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sfdp_in_if  in_ch ();
  sfdp_out_if out_ch ();

  scaled_float_dot_product dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sfdp_scoreboard sb = new();

  // When calm is set neither side idles, so the block is never held up by them.
  bit          calm = 1'b0;
  // The receiver's hold-off: set by the stimulus, counted down below.
  int unsigned hold_cycles = 0;
  int unsigned cycles = 0;
  int unsigned pairs_sent = 0;

  always #1 clk = ~clk;

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.query_element  = '0;
    in_ch.stored_element = '0;
    in_ch.last_element   = 1'b0;
    out_ch.ready         = 1'b0;
  end

  // Cycle limit: a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The result side: random stalls about 13 percent of the time, plus a long
  // hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // Monitor: both channels are sampled at the edge, before any driver
  // update of that edge lands, so the order of processes does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_pair(in_ch.query_element, in_ch.stored_element, in_ch.last_element);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.score, out_ch.raw_sum);
    end
  end

  // Offer one pair and hold it until its transfer. An idle gap may come
  // first; valid is dropped only for the gap, never within one edge.
  task automatic send_pair(sfdp_pkg::fp_t q, sfdp_pkg::fp_t s, bit last);
    if (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.query_element  <= q;
    in_ch.stored_element <= s;
    in_ch.last_element   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly moderate magnitudes so that sums cancel and round in earnest;
  // the rest is raw bits, tiny, huge and special values.
  function automatic sfdp_pkg::fp_t pick_operand();
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 70)
      return {1'($urandom), 8'($urandom_range(140, 110)), 23'($urandom)};
    if (mode < 80)
      return sfdp_pkg::fp_t'($urandom);
    if (mode < 88)
      return {1'($urandom), 8'($urandom_range(3, 0)), 23'($urandom)};
    if (mode < 94)
      return {1'($urandom), 8'($urandom_range(254, 250)), 23'($urandom)};
    case ($urandom_range(5))
      0: return sfdp_pkg::FP_POS_ZERO;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return sfdp_pkg::FP_ONE;
      default: return {1'($urandom), sfdp_pkg::EXP_MAX, 1'($urandom),
                       22'($urandom) | 22'd1};
    endcase
  endfunction

  initial begin
    int unsigned len;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs: zeros, overflow to +inf and -inf, a sum of -inf, inf*0
    // and inf-inf, NaN inputs with payloads, subnormal ties, signed zeros, a
    // plain negative sum, rounding near one, a tie at 2**24, underflow to zero.
    send_pair(sfdp_pkg::FP_POS_ZERO, sfdp_pkg::FP_POS_ZERO, 1'b1);
    send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
    send_pair(32'hFF80_0000, sfdp_pkg::FP_ONE, 1'b1);
    send_pair(32'h7F80_0000, sfdp_pkg::FP_POS_ZERO, 1'b1);
    send_pair(32'h7F80_0000, sfdp_pkg::FP_ONE, 1'b0);
    send_pair(32'hFF80_0000, sfdp_pkg::FP_ONE, 1'b1);
    send_pair(32'h7FC1_2345, sfdp_pkg::FP_ONE, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'h0000_0001, sfdp_pkg::FP_ONE, 1'b0);
    send_pair(32'h0000_0001, 32'h3F00_0000, 1'b1);
    send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_pair(32'h8000_0000, sfdp_pkg::FP_ONE, 1'b1);
    send_pair(32'hBF80_0000, 32'h4000_0000, 1'b1);
    send_pair(32'h3F80_0001, 32'h3F80_0001, 1'b1);
    send_pair(32'h0080_0000, 32'h0080_0000, 1'b1);
    send_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1);
    send_pair(32'h4B80_0000, sfdp_pkg::FP_ONE, 1'b0);
    send_pair(32'h3F80_0000, 32'h3F80_0000, 1'b0);
    send_pair(32'hCB80_0000, sfdp_pkg::FP_ONE, 1'b1);
    send_pair(32'h807F_FFFF, 32'h3F80_0000, 1'b1);

    // Random vectors of one to eight pairs, now and then nine to 24.
    while (pairs_sent < PAIR_TARGET) begin
      calm = (pairs_sent >= 200 && pairs_sent < 350);
      if (!held && pairs_sent >= 450) begin
        // Long receiver hold-off while pairs keep coming, so the output
        // register fills and the input stalls.
        held        = 1'b1;
        hold_cycles = 600;
      end
      if (!paused && pairs_sent >= 850) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        wait_drained();
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int unsigned i = 0; i < len; i++)
        send_pair(pick_operand(), pick_operand(), i == len - 1);
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      if (sb.pending() != 0)
        $error("%0d expected results never arrived", sb.pending());
      $display("simulation failed");
    end
    $finish;
  end
endmodule
